// ----- rtl/ctwg_pkg.sv -----
// ----------------------------------------------------------------------------
// ctwg_pkg
// Shared widths, codes and types of the complex triangle wave generator.
// ----------------------------------------------------------------------------
package ctwg_pkg;

   localparam int PHASE_BITS = 32;
   localparam int TURN_BITS  = 32;
   localparam int INDEX_BITS = 32;
   localparam int ASYM_BITS  = 16;
   localparam int MAG_BITS   = 24;
   localparam int OUT_BITS   = 32;
   localparam int QUOT_BITS  = 32;
   localparam int DIV_WIDTH  = PHASE_BITS + 2;
   localparam int SEG_WIDTH  = PHASE_BITS + 3;
   localparam int PROD_BITS  = QUOT_BITS + MAG_BITS - 1;
   localparam int ROUND_SHIFT = QUOT_BITS - 1;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FREQ = 2'd1,
      STATUS_MAG  = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FREQ  = 2'd0,
      CSR_PHASE = 2'd1,
      CSR_ASYM  = 2'd2,
      CSR_MAG   = 2'd3
   } csr_index_type;

   typedef struct packed {
      status_type status;
      logic       neg_real;
      logic       neg_imag;
   } tag_type;

endpackage

// ----- rtl/ctwg_div.sv -----
// ----------------------------------------------------------------------------
// ctwg_div
// Pipelined restoring divider giving floor(num * 2^31 / den), one quotient
// bit per stage, for 0 <= num <= den.
// ----------------------------------------------------------------------------
module ctwg_div (
   input  logic                                clock,
   input  logic                                advance,
   input  logic [ctwg_pkg::DIV_WIDTH-1:0]      num,
   input  logic [ctwg_pkg::DIV_WIDTH-1:0]      den,
   output logic [ctwg_pkg::QUOT_BITS-1:0]      quot
);

   localparam int STAGES = ctwg_pkg::QUOT_BITS;
   localparam int DW     = ctwg_pkg::DIV_WIDTH;
   localparam int QB     = ctwg_pkg::QUOT_BITS;

   logic [DW-1:0] rem_ff [STAGES];
   logic [DW-1:0] den_ff [STAGES];
   logic [QB-1:0] quo_ff [STAGES];
   logic [DW-1:0] rem_in [STAGES];
   logic [QB-1:0] quo_in [STAGES];

   always_comb begin
      logic [DW-1:0] part;
      if (num >= den) begin
         rem_in[0] = num - den;
         quo_in[0] = QB'(1);
      end else begin
         rem_in[0] = num;
         quo_in[0] = '0;
      end
      for (int i = 1; i < STAGES; i++) begin
         part = {rem_ff[i-1][DW-2:0], 1'b0};
         if (part >= den_ff[i-1]) begin
            rem_in[i] = part - den_ff[i-1];
            quo_in[i] = {quo_ff[i-1][QB-2:0], 1'b1};
         end else begin
            rem_in[i] = part;
            quo_in[i] = {quo_ff[i-1][QB-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         den_ff[0] <= den;
         for (int i = 0; i < STAGES; i++) begin
            rem_ff[i] <= rem_in[i];
            quo_ff[i] <= quo_in[i];
         end
         for (int i = 1; i < STAGES; i++) begin
            den_ff[i] <= den_ff[i-1];
         end
      end
   end

   assign quot = (den_ff[STAGES-1] == '0) ? '0 : quo_ff[STAGES-1];

endmodule

// ----- rtl/complex_triangle_wave_generator_core.sv -----
// ----------------------------------------------------------------------------
// complex_triangle_wave_generator_core
// Gives one complex sample of an asymmetric triangle wave per request.
// The pipeline stages are phase multiply, phase add, two segment stages,
// 32 divider stages, scale multiply and the output register.
// Throughput is one request per cycle; the pipeline halts only while a
// result is held on a stalled response port. Reset clears all valid bits
// and sets the configuration registers to their reset values.
// ----------------------------------------------------------------------------
module complex_triangle_wave_generator_core (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [ctwg_pkg::INDEX_BITS-1:0]           req_sample_index,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [ctwg_pkg::OUT_BITS-1:0]      rsp_real_part,
   output logic signed [ctwg_pkg::OUT_BITS-1:0]      rsp_imag_part,
   output logic [1:0]                                rsp_status,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [ctwg_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [ctwg_pkg::CSR_DATA_BITS-1:0]        csr_data
);

   localparam int PB  = ctwg_pkg::PHASE_BITS;
   localparam int TB  = ctwg_pkg::TURN_BITS;
   localparam int SW  = ctwg_pkg::SEG_WIDTH;
   localparam int DW  = ctwg_pkg::DIV_WIDTH;
   localparam int QB  = ctwg_pkg::QUOT_BITS;
   localparam int MB  = ctwg_pkg::MAG_BITS;
   localparam int AB  = ctwg_pkg::ASYM_BITS;
   localparam int OB  = ctwg_pkg::OUT_BITS;
   localparam int PRB = ctwg_pkg::PROD_BITS;
   localparam int DEPTH = ctwg_pkg::QUOT_BITS;
   localparam logic [TB-1:0] FREQ_LIMIT = TB'(1) << (TB - 1);

   logic [TB-1:0] freq_ff;
   logic [TB-1:0] phase_ff;
   logic [AB-1:0] asym_ff;
   logic [MB-1:0] mag_ff;

   logic advance;

   logic                     s1_valid_ff;
   logic [TB-1:0]            s1_prod_ff;
   ctwg_pkg::status_type     s1_status_ff;
   logic [2*TB-1:0]          mult_full;
   ctwg_pkg::status_type     status_in;

   logic                     s2_valid_ff;
   logic [PB-1:0]            s2_tp_ff;
   ctwg_pkg::status_type     s2_status_ff;
   logic [TB-1:0]            phase_sum;
   logic [PB+TB-1:0]         phase_wide;

   logic                     s3_valid_ff;
   ctwg_pkg::status_type     s3_status_ff;
   logic                     s3_low_real_ff;
   logic                     s3_im1_ff;
   logic                     s3_im2_ff;
   logic signed [SW-1:0]     s3_re_a_ff;
   logic signed [SW-1:0]     s3_re_b_ff;
   logic signed [SW-1:0]     s3_im_a_ff;
   logic signed [SW-1:0]     s3_im_b_ff;
   logic signed [SW-1:0]     s3_im_c_ff;
   logic signed [SW-1:0]     s3_den_h_ff;
   logic signed [SW-1:0]     s3_den_u_ff;
   logic signed [SW-1:0]     t_s;
   logic signed [SW-1:0]     t2_s;
   logic signed [SW-1:0]     u_s;
   logic signed [SW-1:0]     hs_s;
   logic [PB-1:0]            hs;

   logic                     s4_valid_ff;
   ctwg_pkg::tag_type        s4_tag_ff;
   logic [DW-1:0]            s4_num_re_ff;
   logic [DW-1:0]            s4_den_re_ff;
   logic [DW-1:0]            s4_num_im_ff;
   logic [DW-1:0]            s4_den_im_ff;
   logic signed [SW-1:0]     sel_re;
   logic signed [SW-1:0]     sel_im;
   logic signed [SW-1:0]     sel_den_re;
   logic signed [SW-1:0]     sel_den_im;
   logic signed [SW-1:0]     abs_re;
   logic signed [SW-1:0]     abs_im;

   logic                     div_valid_ff [DEPTH];
   ctwg_pkg::tag_type        div_tag_ff   [DEPTH];
   logic [QB-1:0]            quot_re;
   logic [QB-1:0]            quot_im;

   logic                     m1_valid_ff;
   ctwg_pkg::tag_type        m1_tag_ff;
   logic [PRB-1:0]           m1_prod_re_ff;
   logic [PRB-1:0]           m1_prod_im_ff;

   logic                     rsp_valid_ff;
   logic signed [OB-1:0]     rsp_real_ff;
   logic signed [OB-1:0]     rsp_imag_ff;
   ctwg_pkg::status_type     rsp_status_ff;
   logic [PRB-1:0]           round_re;
   logic [PRB-1:0]           round_im;
   logic [OB-1:0]            val_re;
   logic [OB-1:0]            val_im;
   logic signed [OB-1:0]     real_in;
   logic signed [OB-1:0]     imag_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff  <= '0;
         phase_ff <= '0;
         asym_ff  <= '0;
         mag_ff   <= MB'(65536);
      end else if (csr_valid) begin
         unique case (ctwg_pkg::csr_index_type'(csr_index))
            ctwg_pkg::CSR_FREQ:  freq_ff  <= csr_data[TB-1:0];
            ctwg_pkg::CSR_PHASE: phase_ff <= csr_data[TB-1:0];
            ctwg_pkg::CSR_ASYM:  asym_ff  <= csr_data[AB-1:0];
            ctwg_pkg::CSR_MAG:   mag_ff   <= csr_data[MB-1:0];
         endcase
      end
   end

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // Stage 1: phase product and error status.
   assign mult_full = freq_ff * req_sample_index;

   always_comb begin
      if (freq_ff > FREQ_LIMIT) begin
         status_in = ctwg_pkg::STATUS_FREQ;
      end else if (mag_ff[MB-1] || mag_ff == '0) begin
         status_in = ctwg_pkg::STATUS_MAG;
      end else begin
         status_in = ctwg_pkg::STATUS_OK;
      end
   end

   // Stage 2: phase offset and rescale to the phase width.
   assign phase_sum  = s1_prod_ff + phase_ff;
   assign phase_wide = {phase_sum, PB'(0)};

   // Stage 3: segment tests and candidate numerators.
   assign hs   = {~asym_ff[AB-1], asym_ff[AB-2:0], (PB-AB)'(0)};
   assign t_s  = SW'(s2_tp_ff);
   assign t2_s = SW'({s2_tp_ff, 1'b0});
   assign u_s  = SW'(1) << PB;
   assign hs_s = SW'(hs);

   // Stage 4: segment choice and sign split.
   always_comb begin
      if (s3_low_real_ff) begin
         sel_re     = s3_re_a_ff;
         sel_den_re = s3_den_h_ff;
      end else begin
         sel_re     = s3_re_b_ff;
         sel_den_re = s3_den_u_ff;
      end
      if (s3_im1_ff) begin
         sel_im     = s3_im_a_ff;
         sel_den_im = s3_den_u_ff;
      end else if (s3_im2_ff) begin
         sel_im     = s3_im_b_ff;
         sel_den_im = s3_den_h_ff;
      end else begin
         sel_im     = s3_im_c_ff;
         sel_den_im = s3_den_u_ff;
      end
      abs_re = sel_re[SW-1] ? -sel_re : sel_re;
      abs_im = sel_im[SW-1] ? -sel_im : sel_im;
   end

   ctwg_div u_div_re (
      .clock   (clock),
      .advance (advance),
      .num     (s4_num_re_ff),
      .den     (s4_den_re_ff),
      .quot    (quot_re)
   );

   ctwg_div u_div_im (
      .clock   (clock),
      .advance (advance),
      .num     (s4_num_im_ff),
      .den     (s4_den_im_ff),
      .quot    (quot_im)
   );

   // Output stage: rounding, sign and error zeroing.
   always_comb begin
      round_re = m1_prod_re_ff + (PRB'(1) << (ctwg_pkg::ROUND_SHIFT - 1));
      round_im = m1_prod_im_ff + (PRB'(1) << (ctwg_pkg::ROUND_SHIFT - 1));
      val_re   = OB'(round_re >> ctwg_pkg::ROUND_SHIFT);
      val_im   = OB'(round_im >> ctwg_pkg::ROUND_SHIFT);
      if (m1_tag_ff.status != ctwg_pkg::STATUS_OK) begin
         real_in = '0;
         imag_in = '0;
      end else begin
         real_in = m1_tag_ff.neg_real ? -signed'(val_re) : signed'(val_re);
         imag_in = m1_tag_ff.neg_imag ? -signed'(val_im) : signed'(val_im);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         m1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < DEPTH; i++) begin
            div_valid_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         s1_valid_ff     <= req_valid;
         s2_valid_ff     <= s1_valid_ff;
         s3_valid_ff     <= s2_valid_ff;
         s4_valid_ff     <= s3_valid_ff;
         div_valid_ff[0] <= s4_valid_ff;
         for (int i = 1; i < DEPTH; i++) begin
            div_valid_ff[i] <= div_valid_ff[i-1];
         end
         m1_valid_ff  <= div_valid_ff[DEPTH-1];
         rsp_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_prod_ff   <= mult_full[TB-1:0];
         s1_status_ff <= status_in;

         s2_tp_ff     <= phase_wide[PB+TB-1:TB];
         s2_status_ff <= s1_status_ff;

         s3_status_ff   <= s2_status_ff;
         s3_low_real_ff <= t_s < hs_s;
         s3_im1_ff      <= t2_s <= u_s - hs_s;
         s3_im2_ff      <= t2_s <= u_s + hs_s;
         s3_re_a_ff     <= hs_s - t2_s;
         s3_re_b_ff     <= t2_s - u_s - hs_s;
         s3_im_a_ff     <= t2_s;
         s3_im_b_ff     <= u_s - t2_s;
         s3_im_c_ff     <= t2_s - (u_s <<< 1);
         s3_den_h_ff    <= hs_s;
         s3_den_u_ff    <= u_s - hs_s;

         s4_tag_ff.status   <= s3_status_ff;
         s4_tag_ff.neg_real <= sel_re[SW-1];
         s4_tag_ff.neg_imag <= sel_im[SW-1];
         s4_num_re_ff       <= abs_re[DW-1:0];
         s4_num_im_ff       <= abs_im[DW-1:0];
         s4_den_re_ff       <= sel_den_re[DW-1:0];
         s4_den_im_ff       <= sel_den_im[DW-1:0];

         div_tag_ff[0] <= s4_tag_ff;
         for (int i = 1; i < DEPTH; i++) begin
            div_tag_ff[i] <= div_tag_ff[i-1];
         end

         m1_tag_ff     <= div_tag_ff[DEPTH-1];
         m1_prod_re_ff <= PRB'(quot_re) * PRB'(mag_ff[MB-2:0]);
         m1_prod_im_ff <= PRB'(quot_im) * PRB'(mag_ff[MB-2:0]);

         rsp_real_ff   <= real_in;
         rsp_imag_ff   <= imag_in;
         rsp_status_ff <= m1_tag_ff.status;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_real_part = rsp_real_ff;
   assign rsp_imag_part = rsp_imag_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the complex triangle wave generator core. A
// directed table covers reset values, register extremes, the error codes,
// segment boundaries and phase wrap. Random settings with mostly sequential
// sample indices follow. Each response is checked against the table or a
// local model of the wave; most phases add sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 48;
   localparam int PHASE_COUNT  = 9;
   localparam int PHASE_ITEMS  = 61;

   typedef struct packed {
      logic signed [ctwg_pkg::OUT_BITS-1:0] re;
      logic signed [ctwg_pkg::OUT_BITS-1:0] im;
      ctwg_pkg::status_type                 status;
   } wave_sample_type;

   typedef struct {
      logic [ctwg_pkg::TURN_BITS-1:0]        freq;
      logic [ctwg_pkg::TURN_BITS-1:0]        phase;
      logic signed [ctwg_pkg::ASYM_BITS-1:0] asym;
      logic signed [ctwg_pkg::MAG_BITS-1:0]  mag;
      logic [ctwg_pkg::INDEX_BITS-1:0]       index;
      bit                                    known;
      wave_sample_type                       expected;
   } directed_row_type;

   logic                                    clock = 1'b0;
   logic                                    reset = 1'b1;
   logic                                    req_valid = 1'b0;
   logic                                    req_stall;
   logic [ctwg_pkg::INDEX_BITS-1:0]         req_sample_index = '0;
   logic                                    rsp_valid;
   logic                                    rsp_stall = 1'b0;
   logic signed [ctwg_pkg::OUT_BITS-1:0]    rsp_real_part;
   logic signed [ctwg_pkg::OUT_BITS-1:0]    rsp_imag_part;
   logic [1:0]                              rsp_status;
   logic                                    csr_valid = 1'b0;
   logic                                    csr_ready;
   logic [ctwg_pkg::CSR_INDEX_BITS-1:0]     csr_index = ctwg_pkg::CSR_FREQ;
   logic [ctwg_pkg::CSR_DATA_BITS-1:0]      csr_data = '0;

   logic [ctwg_pkg::TURN_BITS-1:0]          cfg_freq  = '0;
   logic [ctwg_pkg::TURN_BITS-1:0]          cfg_phase = '0;
   logic signed [ctwg_pkg::ASYM_BITS-1:0]   cfg_asym  = '0;
   logic signed [ctwg_pkg::MAG_BITS-1:0]    cfg_mag   = 24'sd65536;

   wave_sample_type  pending_samples[$];
   wave_sample_type  front_sample;
   directed_row_type directed_rows[$];

   int tx_idle_pct = 30;
   int rx_idle_pct = 53;
   int mismatch_count = 0;
   int samples_sent = 0;
   int samples_checked = 0;
   int config_loads = 0;
   int error_samples = 0;
   int cycle_count = 0;

   complex_triangle_wave_generator_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_index (req_sample_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_real_part    (rsp_real_part),
      .rsp_imag_part    (rsp_imag_part),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Truncated Q1.31 quotient of num/den with num <= den.
   function automatic longint unsigned q131_quotient(longint unsigned num,
                                                     longint unsigned den);
      longint unsigned q;
      longint unsigned r;
      q = 0;
      r = num;
      if (den == 0) return 0;
      if (r >= den) begin
         r = r - den;
         q = 1;
      end
      for (int i = 0; i < 31; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q = q | 1;
         end
      end
      return q;
   endfunction

   function automatic logic [ctwg_pkg::OUT_BITS-1:0] scaled_segment(longint num,
                                                                    longint den,
                                                                    longint unsigned mag);
      bit              neg;
      longint unsigned an;
      longint unsigned v;
      neg = (num < 0);
      an = neg ? longint'(-num) : longint'(num);
      v = (q131_quotient(an, den) * mag + (64'd1 << 30)) >> 31;
      if (neg) v = 64'd0 - v;
      return v[ctwg_pkg::OUT_BITS-1:0];
   endfunction

   function automatic wave_sample_type triangle_sample(logic [ctwg_pkg::INDEX_BITS-1:0] n);
      wave_sample_type s;
      logic [63:0]     prod;
      logic [31:0]     ph32;
      longint unsigned tp;
      longint          tv;
      longint          uv;
      longint          hv;
      longint          magv;
      s.re = '0;
      s.im = '0;
      s.status = ctwg_pkg::STATUS_OK;
      if (cfg_freq > 32'h8000_0000) begin
         s.status = ctwg_pkg::STATUS_FREQ;
         return s;
      end
      if (cfg_mag <= 0) begin
         s.status = ctwg_pkg::STATUS_MAG;
         return s;
      end
      prod = {32'd0, cfg_freq} * {32'd0, n} + {32'd0, cfg_phase};
      ph32 = prod[31:0];
      if (ctwg_pkg::PHASE_BITS >= 32) tp = longint'(ph32) << (ctwg_pkg::PHASE_BITS - 32);
      else tp = longint'(ph32) >> (32 - ctwg_pkg::PHASE_BITS);
      uv = longint'(64'd1 << ctwg_pkg::PHASE_BITS);
      tv = longint'(tp);
      hv = (longint'(cfg_asym) + 32768) << (ctwg_pkg::PHASE_BITS - 16);
      magv = longint'(cfg_mag);
      if (tv < hv) s.re = scaled_segment(hv - 2 * tv, hv, magv);
      else s.re = scaled_segment(2 * tv - uv - hv, uv - hv, magv);
      if (2 * tv <= uv - hv) s.im = scaled_segment(2 * tv, uv - hv, magv);
      else if (2 * tv <= uv + hv) s.im = scaled_segment(uv - 2 * tv, hv, magv);
      else s.im = scaled_segment(2 * tv - 2 * uv, uv - hv, magv);
      return s;
   endfunction

   function automatic void add_row(logic [31:0] freq, logic [31:0] phase,
                                   logic signed [15:0] asym, logic signed [23:0] mag,
                                   logic [31:0] index, bit known,
                                   logic signed [31:0] re, logic signed [31:0] im,
                                   ctwg_pkg::status_type status);
      directed_row_type row;
      row.freq = freq;
      row.phase = phase;
      row.asym = asym;
      row.mag = mag;
      row.index = index;
      row.known = known;
      row.expected.re = re;
      row.expected.im = im;
      row.expected.status = status;
      directed_rows.push_back(row);
   endfunction

   task automatic send_sample(input logic [ctwg_pkg::INDEX_BITS-1:0] idx,
                              input wave_sample_type expected);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_index <= idx;
      pending_samples.push_back(expected);
      if (expected.status != ctwg_pkg::STATUS_OK) error_samples++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      samples_sent++;
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input logic [31:0] freq, input logic [31:0] phase,
                               input logic signed [15:0] asym,
                               input logic signed [23:0] mag);
      logic [31:0]             noise;
      logic [31:0]             values [4];
      ctwg_pkg::csr_index_type order [4];
      noise = $urandom;
      order = '{ctwg_pkg::CSR_FREQ, ctwg_pkg::CSR_PHASE, ctwg_pkg::CSR_ASYM,
                ctwg_pkg::CSR_MAG};
      values[0] = freq;
      values[1] = phase;
      values[2] = {noise[31:16], asym};
      values[3] = {noise[7:0], mag};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= order[i];
         csr_data <= values[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      cfg_freq = freq;
      cfg_phase = phase;
      cfg_asym = asym;
      cfg_mag = mag;
      config_loads++;
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_samples.size() == 0) begin
            $error("response with no request pending");
            mismatch_count++;
         end else begin
            front_sample = pending_samples.pop_front();
            samples_checked++;
            if (rsp_real_part !== front_sample.re) begin
               $error("real_part: expected %0d, actual %0d", front_sample.re, rsp_real_part);
               mismatch_count++;
            end
            if (rsp_imag_part !== front_sample.im) begin
               $error("imag_part: expected %0d, actual %0d", front_sample.im, rsp_imag_part);
               mismatch_count++;
            end
            if (rsp_status !== front_sample.status) begin
               $error("status: expected %0d, actual %0d", front_sample.status, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      directed_row_type                row;
      logic [31:0]                     freq;
      logic [31:0]                     phase;
      logic signed [15:0]              asym;
      logic signed [23:0]              mag;
      logic [31:0]                     tmp;
      logic [ctwg_pkg::INDEX_BITS-1:0] idx;
      logic [ctwg_pkg::INDEX_BITS-1:0] next_index;

      add_row(32'h0, 32'h0, 16'sd0, 24'sd65536, 32'h0, 1, 65536, 0, ctwg_pkg::STATUS_OK);
      add_row(32'h0, 32'h0, 16'sd0, 24'sd65536, 32'hFFFF_FFFF, 1, 65536, 0,
              ctwg_pkg::STATUS_OK);
      add_row(32'h0, 32'h8000_0000, 16'sd0, 24'sd65536, 32'h0, 1, -65536, 0,
              ctwg_pkg::STATUS_OK);
      add_row(32'h0, 32'h4000_0000, 16'sd0, 24'sd65536, 32'h0, 1, 0, 65536,
              ctwg_pkg::STATUS_OK);
      add_row(32'h0, 32'hC000_0000, 16'sd0, 24'sd65536, 32'h0, 1, 0, -65536,
              ctwg_pkg::STATUS_OK);
      add_row(32'h0, 32'h0, 16'sh8000, 24'sd65536, 32'h0, 1, -65536, 0,
              ctwg_pkg::STATUS_OK);
      add_row(32'h0, 32'h8000_0000, 16'sh8000, 24'sd65536, 32'h0, 1, 0, 65536,
              ctwg_pkg::STATUS_OK);
      add_row(32'h0, 32'h0, 16'sh7FFF, 24'sd65536, 32'h0, 1, 65536, 0,
              ctwg_pkg::STATUS_OK);
      add_row(32'h0, 32'hFFFF_FFFF, 16'sh7FFF, 24'sd65536, 32'h0, 0, 0, 0,
              ctwg_pkg::STATUS_OK);
      add_row(32'h0, 32'h0, 16'sd0, 24'sh7FFFFF, 32'h0, 1, 8388607, 0,
              ctwg_pkg::STATUS_OK);
      add_row(32'h0, 32'h0, 16'sd0, 24'sd1, 32'h0, 1, 1, 0, ctwg_pkg::STATUS_OK);
      add_row(32'h0, 32'h8000_0000, 16'sd0, 24'sh7FFFFF, 32'h0, 1, -8388607, 0,
              ctwg_pkg::STATUS_OK);
      add_row(32'h0, 32'h0, 16'sd0, 24'sd0, 32'h0, 1, 0, 0, ctwg_pkg::STATUS_MAG);
      add_row(32'h0, 32'h0, 16'sd0, 24'sh800000, 32'h1234_5678, 1, 0, 0,
              ctwg_pkg::STATUS_MAG);
      add_row(32'h8000_0001, 32'h0, 16'sd0, 24'sd65536, 32'h0, 1, 0, 0,
              ctwg_pkg::STATUS_FREQ);
      add_row(32'hFFFF_FFFF, 32'h0, 16'sd0, -24'sd1, 32'hFFFF_FFFF, 1, 0, 0,
              ctwg_pkg::STATUS_FREQ);
      add_row(32'h8000_0000, 32'h8000_0000, 16'sd0, 24'sd65536, 32'd3, 1, 65536, 0,
              ctwg_pkg::STATUS_OK);
      add_row(32'h8000_0000, 32'h0, 16'sd0, 24'sd65536, 32'hFFFF_FFFF, 0, 0, 0,
              ctwg_pkg::STATUS_OK);
      add_row(32'h1234_5679, 32'h9ABC_DEF0, 16'sh1234, 24'sh0ABCDE, 32'hA5A5_A5A5, 0, 0, 0,
              ctwg_pkg::STATUS_OK);
      add_row(32'h0001_0000, 32'h0, -16'sd16384, 24'sd65536, 32'h5A5A_5A5A, 0, 0, 0,
              ctwg_pkg::STATUS_OK);
      add_row(32'h7FFF_FFFF, 32'h1357_9BDF, -16'sd20000, 24'sh7FFFFF, 32'h0F0F_0F0F, 0, 0, 0,
              ctwg_pkg::STATUS_OK);
      add_row(32'h0000_0001, 32'hFFFF_FFFF, 16'sh7FFF, 24'sd1, 32'hFFFF_FFFE, 0, 0, 0,
              ctwg_pkg::STATUS_OK);
      add_row(32'h5555_5555, 32'h2468_ACE0, 16'sd1000, 24'sh123456, 32'h0000_0001, 0, 0, 0,
              ctwg_pkg::STATUS_OK);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         if (row.freq !== cfg_freq || row.phase !== cfg_phase ||
             row.asym !== cfg_asym || row.mag !== cfg_mag) begin
            drain_pipeline();
            write_config(row.freq, row.phase, row.asym, row.mag);
         end
         send_sample(row.index, row.known ? row.expected : triangle_sample(row.index));
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p == 3) begin
            tx_idle_pct = 53;
            rx_idle_pct = 30;
         end else if (p == 6) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         case ($urandom_range(9))
            0: freq = 32'h0;
            1: freq = 32'h8000_0000;
            2: freq = $urandom_range(32'hFFFF_FFFF, 32'h8000_0001);
            3, 4: freq = $urandom_range(32'h0000_FFFF, 1);
            default: freq = $urandom_range(32'h8000_0000, 0);
         endcase
         phase = $urandom;
         tmp = $urandom;
         case ($urandom_range(5))
            0: asym = 16'sh8000;
            1: asym = 16'sh7FFF;
            2: asym = 16'sd0;
            default: asym = tmp[15:0];
         endcase
         case ($urandom_range(9))
            0: mag = 24'sd1;
            1: mag = 24'sh7FFFFF;
            2: mag = $urandom_range(1) ? 24'sd0 : {1'b1, tmp[30:8]};
            default: mag = 24'($urandom_range(24'h7FFFFF, 1));
         endcase
         drain_pipeline();
         write_config(freq, phase, asym, mag);
         next_index = $urandom;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 4 && k == PHASE_ITEMS / 2) begin
               req_valid <= 1'b0;
               while (pending_samples.size() != 0) @(posedge clock);
            end
            if ($urandom_range(99) < 20) idx = $urandom;
            else idx = next_index;
            next_index = idx + 1;
            send_sample(idx, triangle_sample(idx));
         end
      end

      drain_pipeline();
      if (pending_samples.size() != 0) begin
         $error("%0d expected responses never arrived", pending_samples.size());
         mismatch_count++;
      end
      $display("Sent %0d sample requests over %0d register settings, %0d with error status.",
               samples_sent, config_loads, error_samples);
      $display("Checked %0d responses, %0d mismatches.", samples_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
